// ===== sv/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// pip_pkg: shared types for the point-in-polygon tester
// Sequencer states, item kind codes and the read-control beat tag.
// ----------------------------------------------------------------------------
`default_nettype none

package pip_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN
    } t_state;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Tag that travels with a vertex store read.
    typedef struct packed {
        logic vld;    // read data valid
        logic first;  // seed read: last vertex, opens the wrap edge
    } t_rd_ctl;

endpackage

`default_nettype wire

// ===== sv/pip_vtx_mem.sv =====
// ----------------------------------------------------------------------------
// pip_vtx_mem: vertex store
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_vtx_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64,
    parameter int AW    = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/pip_edge_unit.sv =====
// ----------------------------------------------------------------------------
// pip_edge_unit: per-edge crossing test
// Takes one vertex per cycle from the store, pairs it with the previous one,
// runs the exact cross-multiply compare in a short pipeline and keeps parity.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_edge_unit
    import pip_pkg::*;
#(
    parameter int CW = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire t_rd_ctl              i_ctl,
    input  wire logic [2*CW-1:0]      i_vtx,
    input  wire logic signed [CW-1:0] i_qx,
    input  wire logic signed [CW-1:0] i_qy,
    output logic                      o_parity,
    output logic                      o_busy
);

    localparam int DW = CW + 1;        // difference width
    localparam int PW = 2 * DW;        // full product width
    localparam int LO = DW / 2;        // low split of the second factor
    localparam int HI = DW - LO;

    logic signed [CW-1:0] w_xi, w_yi;
    logic signed [CW-1:0] r_px, r_py;  // previous vertex (j)
    logic                 w_straddle, w_cand;
    logic signed [DW-1:0] w_ay, w_bx, w_ax, w_d;

    // stage 1: differences
    logic                 r_s1_vld, r_s1_dpos;
    logic signed [DW-1:0] r_ay, r_bx, r_ax, r_d;
    // stage 2: partial products
    logic                       r_s2_vld, r_s2_dpos;
    logic signed [DW+LO:0]      r_l_lo, r_r_lo;
    logic signed [DW+HI-1:0]    r_l_hi, r_r_hi;
    // stage 3: full products
    logic                 r_s3_vld, r_s3_dpos;
    logic signed [PW-1:0] r_lhs, r_rhs;

    logic r_parity;
    logic w_left;

    assign w_xi = i_vtx[2*CW-1:CW];
    assign w_yi = i_vtx[CW-1:0];

    assign w_straddle = (w_yi < i_qy && r_py >= i_qy) || (r_py < i_qy && w_yi >= i_qy);
    assign w_cand     = (w_xi <= i_qx) || (r_px <= i_qx);

    assign w_ay = DW'(i_qy) - DW'(w_yi);
    assign w_bx = DW'(r_px) - DW'(w_xi);
    assign w_ax = DW'(i_qx) - DW'(w_xi);
    assign w_d  = DW'(r_py) - DW'(w_yi);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_parity <= 1'b0;
        end else begin
            r_s1_vld <= i_ctl.vld && !i_ctl.first && w_straddle && w_cand;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            if (i_start) begin
                r_parity <= 1'b0;
            end else if (r_s3_vld && w_left) begin
                r_parity <= ~r_parity;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_ctl.vld) begin
            r_px <= w_xi;
            r_py <= w_yi;
        end
        r_ay      <= w_ay;
        r_bx      <= w_bx;
        r_ax      <= w_ax;
        r_d       <= w_d;
        r_s1_dpos <= !w_d[DW-1] && (w_d != '0);

        r_l_lo    <= r_ay * $signed({1'b0, r_bx[LO-1:0]});
        r_l_hi    <= r_ay * $signed(r_bx[DW-1:LO]);
        r_r_lo    <= r_ax * $signed({1'b0, r_d[LO-1:0]});
        r_r_hi    <= r_ax * $signed(r_d[DW-1:LO]);
        r_s2_dpos <= r_s1_dpos;

        r_lhs     <= PW'(r_l_lo) + (PW'(r_l_hi) <<< LO);
        r_rhs     <= PW'(r_r_lo) + (PW'(r_r_hi) <<< LO);
        r_s3_dpos <= r_s2_dpos;
    end

    // crossing strictly left of the point
    assign w_left = r_s3_dpos ? (r_lhs < r_rhs) : (r_rhs < r_lhs);

    assign o_parity = r_parity;
    assign o_busy   = r_s1_vld || r_s2_vld || r_s3_vld;

endmodule

`default_nettype wire

// ===== sv/point_in_polygon_test_top.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_test_top: crossing-number point-in-polygon tester
// Vertex store plus an edge walker that returns an even-odd inside flag.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready): each beat is a load (i_kind = 0)
//   that writes vertex i_vertex_index, or a query (i_kind = 1) of one point.
//   Loads with an index of MAX_VERTICES or more are dropped. Loads produce
//   no result beat.
//   Output channel (o_out_valid / i_out_ready): one beat per query carrying
//   o_inside_res, 1 when the point lies inside by odd crossing count.
//   Config: i_cfg_we writes vertex_count (saturated to MAX_VERTICES); write
//   only while the block is idle.
// Sequence:
//   A query with n vertices makes n + 1 store reads (the last vertex first
//   to open the wrap edge), then passes the registered store read, a
//   three-stage multiply/compare pipeline and the output register that
//   posts the result; an empty polygon goes straight to posting. One item
//   is in flight at a time; the input is taken again once the result has been posted.
// Reset: clears vertex_count, the sequencer and the output valid. Vertex
//   store contents are undefined until loaded.
// Stall: a finished result waits in the output register; the next item is
//   still taken, and a further query holds at its end until the slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module point_in_polygon_test_top
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_WIDTH  = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // config
    input  wire logic               i_cfg_we,
    input  wire logic [6:0]         i_cfg_wdata,
    // input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_kind,
    input  wire logic [5:0]         i_vertex_index,
    input  wire logic signed [31:0] i_x_coord,
    input  wire logic signed [31:0] i_y_coord,
    // output channel
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_inside_res
);

    localparam int CW   = COORD_WIDTH;
    localparam int AW   = $clog2(MAX_VERTICES);
    localparam int CNTW = $clog2(MAX_VERTICES + 1);

    t_state r_state, n_state;

    logic [6:0]      r_vcount;
    logic [CNTW-1:0] w_n;           // saturated vertex count
    logic [CNTW-1:0] r_rd_cnt, n_rd_cnt;

    logic signed [CW-1:0] w_cx, w_cy;  // coordinates at store width
    logic signed [CW-1:0] r_qx, r_qy;  // query point

    logic            w_in_beat, w_load, w_query, w_load_ok;
    logic            w_rd_en;
    logic [AW-1:0]   w_raddr;
    t_rd_ctl         r_mctl;         // aligned with store read data
    logic [2*CW-1:0] w_rdata;

    logic w_parity, w_busy;
    logic w_done;                    // walk finished, result ready to post

    logic r_out_vld, r_inside;

    // coordinate width conversion
    generate
        if (CW <= 32) begin : g_narrow
            assign w_cx = i_x_coord[CW-1:0];
            assign w_cy = i_y_coord[CW-1:0];
        end else begin : g_wide
            assign w_cx = {{(CW-32){i_x_coord[31]}}, i_x_coord};
            assign w_cy = {{(CW-32){i_y_coord[31]}}, i_y_coord};
        end
    endgenerate

    // vertex_count saturates at the store depth
    always_comb begin
        if (32'(r_vcount) > 32'(MAX_VERTICES)) begin
            w_n = CNTW'(MAX_VERTICES);
        end else begin
            w_n = CNTW'(r_vcount);
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_beat  = i_in_valid && o_in_ready;
    assign w_load     = w_in_beat && (i_kind == KIND_LOAD);
    assign w_query    = w_in_beat && (i_kind == KIND_QUERY);
    assign w_load_ok  = w_load && (32'(i_vertex_index) < 32'(MAX_VERTICES));

    // sequencer: next state, read issue
    always_comb begin
        n_state  = r_state;
        n_rd_cnt = r_rd_cnt;
        w_rd_en  = 1'b0;
        w_raddr  = '0;
        w_done   = 1'b0;
        case (r_state)
            S_IDLE: begin
                n_rd_cnt = '0;
                if (w_query) begin
                    // empty polygon: nothing to walk
                    n_state = (w_n == '0) ? S_DRAIN : S_WALK;
                end
            end
            S_WALK: begin
                w_rd_en = 1'b1;
                // seed read of the last vertex, then vertices 0 .. n-1
                if (r_rd_cnt == '0) begin
                    w_raddr = AW'(w_n - CNTW'(1));
                end else begin
                    w_raddr = AW'(r_rd_cnt - CNTW'(1));
                end
                n_rd_cnt = r_rd_cnt + CNTW'(1);
                if (r_rd_cnt == w_n) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_mctl.vld && !w_busy && (!r_out_vld || i_out_ready)) begin
                    w_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_cnt    <= '0;
            r_vcount    <= '0;
            r_mctl      <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_rd_cnt     <= n_rd_cnt;
            r_mctl.vld   <= w_rd_en;
            r_mctl.first <= w_rd_en && (r_rd_cnt == '0);
            if (i_cfg_we) begin
                r_vcount <= i_cfg_wdata;
            end
            if (w_done) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_qx <= w_cx;
            r_qy <= w_cy;
        end
        if (w_done) begin
            r_inside <= w_parity;
        end
    end

    pip_vtx_mem #(
        .DEPTH (MAX_VERTICES),
        .WIDTH (2 * CW),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_load_ok),
        .i_waddr (AW'(i_vertex_index)),
        .i_wdata ({w_cx, w_cy}),
        .i_re    (w_rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    pip_edge_unit #(
        .CW (CW)
    ) u_edge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_query),
        .i_ctl    (r_mctl),
        .i_vtx    (w_rdata),
        .i_qx     (r_qx),
        .i_qy     (r_qy),
        .o_parity (w_parity),
        .o_busy   (w_busy)
    );

    assign o_out_valid  = r_out_vld;
    assign o_inside_res = r_inside;

endmodule

`default_nettype wire
